### rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bus decoder package
// Shared types, address map constants and operation codes for the CPU bus
// decoder with its two serial pad ports.
// ----------------------------------------------------------------------------
package cbd_pkg;

    // Work RAM size in bytes. Must be a power of two no larger than 8192,
    // so the mirrored index is the low address bits.
    localparam int RAM_BYTES = 2048;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    // Bus commands.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Route codes reported with every result.
    localparam logic [2:0] ROUTE_RAM  = 3'd0;
    localparam logic [2:0] ROUTE_PPU  = 3'd1;
    localparam logic [2:0] ROUTE_PAD  = 3'd2;
    localparam logic [2:0] ROUTE_STUB = 3'd3;
    localparam logic [2:0] ROUTE_CART = 3'd4;

    // Address map.
    localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
    localparam logic [15:0] ADDR_DMA       = 16'h4014;
    localparam logic [15:0] ADDR_PAD1      = 16'h4016;
    localparam logic [15:0] ADDR_PAD2      = 16'h4017;
    localparam logic [15:0] ADDR_CART_BASE = 16'h4020;

    // Bit of the pad port write data that drives the strobe.
    localparam int STROBE_BIT = 0;

    // Side-effect class of a queued operation.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_RAM_RD = 3'd1;
    localparam logic [2:0] KIND_RAM_WR = 3'd2;
    localparam logic [2:0] KIND_PAD_RD = 3'd3;
    localparam logic [2:0] KIND_PAD_WR = 3'd4;

    typedef struct packed {
        logic        command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  pad1_buttons;
        logic [7:0]  pad2_buttons;
    } bus_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  route;
        logic [2:0]  ppu_register;
        logic [15:0] forward_address;
        logic [7:0]  forward_data;
        logic        dma_start;
        logic [7:0]  sprite_page;
    } bus_rsp_t;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic [2:0]        kind;
        logic              pad_sel;
        logic [RAM_AW-1:0] ram_index;
        logic [7:0]        write_data;
        logic [7:0]        pad1_buttons;
        logic [7:0]        pad2_buttons;
        bus_rsp_t          rsp;
    } cbd_op_t;

endpackage

### rtl/cbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bus decoder front end
// Accepts bus requests, classifies them against the address map and holds
// the classified operations in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cbd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bus_valid,
    output logic              bus_ready,
    input  cbd_pkg::bus_req_t bus_req,
    output logic              op_valid,
    input  logic              op_pop,
    output cbd_pkg::cbd_op_t  op
);

    cbd_pkg::cbd_op_t dec_op;
    cbd_pkg::cbd_op_t queue_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    // Address decode of the incoming request.
    always_comb
    begin
        dec_op                    = '0;
        dec_op.kind               = cbd_pkg::KIND_NONE;
        dec_op.ram_index          = bus_req.address[cbd_pkg::RAM_AW-1:0];
        dec_op.write_data         = bus_req.write_data;
        dec_op.pad1_buttons       = bus_req.pad1_buttons;
        dec_op.pad2_buttons       = bus_req.pad2_buttons;
        dec_op.rsp.route          = cbd_pkg::ROUTE_STUB;
        if (bus_req.address < cbd_pkg::ADDR_PPU_BASE)
        begin
            dec_op.rsp.route = cbd_pkg::ROUTE_RAM;
            dec_op.kind      = (bus_req.command == cbd_pkg::CMD_WRITE) ?
                               cbd_pkg::KIND_RAM_WR : cbd_pkg::KIND_RAM_RD;
        end
        else if (bus_req.address < cbd_pkg::ADDR_IO_BASE)
        begin
            dec_op.rsp.route        = cbd_pkg::ROUTE_PPU;
            dec_op.rsp.ppu_register = bus_req.address[2:0];
            if (bus_req.command == cbd_pkg::CMD_WRITE)
            begin
                dec_op.rsp.forward_data = bus_req.write_data;
            end
        end
        else if (bus_req.address < cbd_pkg::ADDR_CART_BASE)
        begin
            if (bus_req.command == cbd_pkg::CMD_WRITE)
            begin
                if (bus_req.address == cbd_pkg::ADDR_DMA)
                begin
                    dec_op.rsp.dma_start   = 1'b1;
                    dec_op.rsp.sprite_page = bus_req.write_data;
                end
                else if (bus_req.address == cbd_pkg::ADDR_PAD1)
                begin
                    dec_op.rsp.route = cbd_pkg::ROUTE_PAD;
                    dec_op.kind      = cbd_pkg::KIND_PAD_WR;
                end
            end
            else
            begin
                if (bus_req.address == cbd_pkg::ADDR_PAD1)
                begin
                    dec_op.rsp.route = cbd_pkg::ROUTE_PAD;
                    dec_op.kind      = cbd_pkg::KIND_PAD_RD;
                    dec_op.pad_sel   = 1'b0;
                end
                else if (bus_req.address == cbd_pkg::ADDR_PAD2)
                begin
                    dec_op.rsp.route = cbd_pkg::ROUTE_PAD;
                    dec_op.kind      = cbd_pkg::KIND_PAD_RD;
                    dec_op.pad_sel   = 1'b1;
                end
            end
        end
        else
        begin
            dec_op.rsp.route           = cbd_pkg::ROUTE_CART;
            dec_op.rsp.forward_address = bus_req.address;
            if (bus_req.command == cbd_pkg::CMD_WRITE)
            begin
                dec_op.rsp.forward_data = bus_req.write_data;
            end
        end
    end

    // Queue handshake and pointer updates.
    assign bus_ready = (count_reg != 2'd2);
    assign push      = bus_valid && bus_ready;
    assign pop       = op_pop && op_valid;
    assign op_valid  = (count_reg != 2'd0);
    assign op        = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec_op;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");
`endif

endmodule

### rtl/cbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bus decoder back end
// Carries out classified requests in order: work RAM access, pad shift and
// strobe handling, and drives the registered result toward the consumer.
// ----------------------------------------------------------------------------
module cbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_pop,
    input  cbd_pkg::cbd_op_t  op,
    output logic              res_valid,
    input  logic              res_ready,
    output cbd_pkg::bus_rsp_t res_data
);

    logic [7:0]        ram [cbd_pkg::RAM_BYTES];
    logic [7:0]        ram_q_reg;
    logic              ram_rd_reg;
    cbd_pkg::bus_rsp_t rsp_reg;
    cbd_pkg::bus_rsp_t rsp_next;
    logic              res_valid_reg;
    logic [7:0]        pad_shift_reg [2];
    logic [7:0]        pad_shift_next [2];
    logic              strobe_reg;
    logic              strobe_next;
    logic              pad_bit;
    logic              fire;

    // Take the next operation whenever the result register is free.
    assign fire   = op_valid && (!res_valid_reg || res_ready);
    assign op_pop = fire;

    // Pad shift registers and strobe flag.
    always_comb
    begin
        pad_shift_next[0] = pad_shift_reg[0];
        pad_shift_next[1] = pad_shift_reg[1];
        strobe_next       = strobe_reg;
        pad_bit           = pad_shift_reg[op.pad_sel][0];
        if (fire && op.kind == cbd_pkg::KIND_PAD_RD)
        begin
            pad_shift_next[op.pad_sel] = {1'b0, pad_shift_reg[op.pad_sel][7:1]};
        end
        else if (fire && op.kind == cbd_pkg::KIND_PAD_WR)
        begin
            if (op.write_data[cbd_pkg::STROBE_BIT])
            begin
                strobe_next = 1'b1;
            end
            else if (strobe_reg)
            begin
                pad_shift_next[0] = op.pad1_buttons;
                pad_shift_next[1] = op.pad2_buttons;
                strobe_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_shift_reg[0] <= 8'd0;
            pad_shift_reg[1] <= 8'd0;
            strobe_reg       <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            pad_shift_reg[0] <= pad_shift_next[0];
            pad_shift_reg[1] <= pad_shift_next[1];
            strobe_reg       <= strobe_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Work RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (fire && op.kind == cbd_pkg::KIND_RAM_WR)
        begin
            ram[op.ram_index] <= op.write_data;
        end
        if (fire && op.kind == cbd_pkg::KIND_RAM_RD)
        begin
            ram_q_reg <= ram[op.ram_index];
        end
    end

    // Result register; the pad bit rides in the read data field.
    always_comb
    begin
        rsp_next = op.rsp;
        if (op.kind == cbd_pkg::KIND_PAD_RD)
        begin
            rsp_next.read_data = {7'd0, pad_bit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg    <= rsp_next;
            ram_rd_reg <= (op.kind == cbd_pkg::KIND_RAM_RD);
        end
    end

    always_comb
    begin
        res_data = rsp_reg;
        if (ram_rd_reg)
        begin
            res_data.read_data = ram_q_reg;
        end
    end

    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_dma_is_stub: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.dma_start |-> res_data.route == cbd_pkg::ROUTE_STUB)
        else $error("DMA request reported on a route other than stub");

    a_pad_load: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op.kind == cbd_pkg::KIND_PAD_WR && !op.write_data[cbd_pkg::STROBE_BIT]
        && strobe_reg
        |=> !strobe_reg && pad_shift_reg[0] == $past(op.pad1_buttons)
        && pad_shift_reg[1] == $past(op.pad2_buttons))
        else $error("pads not loaded on strobe release");

    a_pad_shift: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op.kind == cbd_pkg::KIND_PAD_RD && !op.pad_sel
        |=> pad_shift_reg[0] == {1'b0, $past(pad_shift_reg[0][7:1])})
        else $error("pad one did not shift on read");

    a_pad_bit_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.route == cbd_pkg::ROUTE_PAD
        |-> res_data.read_data[7:1] == 7'd0)
        else $error("pad read returned more than one bit");
`endif

endmodule

### rtl/console_bus_decoder_with_pad_ports_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bus decoder with pad ports, top level
// CPU bus access decoder: mirrored work RAM, picture unit and cartridge
// routing, DMA request and two serial pad ports.
// ----------------------------------------------------------------------------
// A request's result passes through the front queue and then the result
// register before it reaches the output.
// Throughput: one request per cycle while res_ready is high, set by the
// single-port work RAM and the in-order back end (one request per cycle).
// Reset clears the queue, the pad shift registers and the strobe flag at
// once; work RAM contents are undefined until written and need no clear.
module console_bus_decoder_with_pad_ports_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bus_valid,
    output logic              bus_ready,
    input  cbd_pkg::bus_req_t bus_req,
    output logic              res_valid,
    input  logic              res_ready,
    output cbd_pkg::bus_rsp_t res_data
);

    logic             op_valid;
    logic             op_pop;
    cbd_pkg::cbd_op_t op;

    // Front end: decode and queue.
    cbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus_valid (bus_valid),
        .bus_ready (bus_ready),
        .bus_req   (bus_req),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op        (op)
    );

    // Back end: execute and report.
    cbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
